@@ src/mfde_pkg.sv @@
// ----------------------------------------------------------------------------
// mfde_pkg
// Shared types and constants of the monochrome frame-store draw engine.
// ----------------------------------------------------------------------------
package mfde_pkg;

    localparam int SCREEN_COLUMNS = 128;
    localparam int SCREEN_ROWS    = 128;
    localparam int STORE_DEPTH    = 2048;
    localparam int ADDR_W         = 11;
    localparam int QUEUE_DEPTH    = 2;

    typedef enum logic [2:0] {
        ACT_CLEAR  = 3'd0,
        ACT_PIXEL  = 3'd1,
        ACT_LINE   = 3'd2,
        ACT_CIRCLE = 3'd3,
        ACT_RECT   = 3'd4,
        ACT_READ   = 3'd5,
        ACT_BAD6   = 3'd6,
        ACT_BAD7   = 3'd7
    } action_t;

    // One classified command as it sits in the queue
    typedef struct packed {
        action_t     action;
        logic [7:0]  x_first;
        logic [7:0]  y_first;
        logic [7:0]  x_second;
        logic [7:0]  y_second;
        logic [7:0]  radius;
        logic [7:0]  rect_width;
        logic [7:0]  rect_height;
        logic        color;
        logic [10:0] read_index;
    } cmd_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_PT_GEN,
        ST_PT_READ,
        ST_PT_WAIT,
        ST_PT_WRITE,
        ST_RD_READ,
        ST_RD_WAIT,
        ST_DONE
    } state_t;

    // Shape generator classes
    typedef enum logic [1:0] {
        GEN_PIXEL,
        GEN_LINE,
        GEN_CIRCLE,
        GEN_RECT
    } gen_t;

endpackage

@@ src/mfde_ram.sv @@
// ----------------------------------------------------------------------------
// mfde_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module mfde_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write or read one entry
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

@@ src/mfde_front.sv @@
// ----------------------------------------------------------------------------
// mfde_front
// Accepts commands and holds them in a short queue for the drawing back end.
// ----------------------------------------------------------------------------
module mfde_front (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    output logic            in_ready,
    input  mfde_pkg::cmd_t  in_cmd,
    output logic            q_valid,
    input  logic            q_ready,
    output mfde_pkg::cmd_t  q_cmd
);

    mfde_pkg::cmd_t slot_reg [mfde_pkg::QUEUE_DEPTH];
    logic           wp_reg, rp_reg;
    logic [1:0]     cnt_reg;
    logic           push, pop;

    assign in_ready = (cnt_reg != 2'(mfde_pkg::QUEUE_DEPTH));
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_cmd    = slot_reg[rp_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    // Store a transfer in the next free slot
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wp_reg] <= in_cmd;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            if (push) wp_reg <= ~wp_reg;
            if (pop)  rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end

    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == 2'd0) |-> !pop) else $error("pop from empty queue");
    a_full_no_push: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == 2'd2) |-> !push) else $error("push into full queue");
    a_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop && cnt_reg == 2'd0) |=> (cnt_reg == 2'd1))
        else $error("queue count slip");

endmodule

@@ src/mfde_back.sv @@
// ----------------------------------------------------------------------------
// mfde_back
// Runs one command: clear sweep, point generators and read-modify-write.
// ----------------------------------------------------------------------------
module mfde_back (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            q_valid,
    output logic            q_ready,
    input  mfde_pkg::cmd_t  q_cmd,
    output logic            m_valid,
    input  logic            m_ready,
    output logic [7:0]      m_read_data,
    output logic [2:0]      m_done_action
);

    mfde_pkg::state_t state_reg, state_next;
    mfde_pkg::cmd_t   cmd_reg;
    mfde_pkg::gen_t   gen_reg;

    // Clear sweep, runs once after reset as well
    logic [mfde_pkg::ADDR_W-1:0] clr_reg;
    logic                        init_reg;

    // Generator state (signed, wide enough for full-range arithmetic)
    logic signed [10:0] xa_reg, ya_reg;       // line point / circle px,py
    logic signed [10:0] err_reg;
    logic signed [10:0] dx_reg, dy_reg;
    logic signed [1:0]  sx_reg, sy_reg;
    logic [2:0]         oct_reg;
    logic [8:0]         rc_reg, rr_reg;       // rectangle column/row offsets
    logic               last_reg;             // current point closes shape

    logic signed [10:0] pc_reg, pr_reg;       // point to plot
    logic               on_reg;
    logic [7:0]         data_reg;

    // Memory port
    logic                      we;
    logic [mfde_pkg::ADDR_W-1:0] addr;
    logic [7:0]                wdata, rdata;

    mfde_ram #(.WIDTH(8), .DEPTH(mfde_pkg::STORE_DEPTH)) u_ram (
        .aclk(aclk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
    );

    // Point address and clip
    logic        pt_in;
    logic [15:0] pt_addr_w;
    assign pt_in = (pc_reg >= 0) && (pr_reg >= 0) &&
                   (pc_reg < 11'(mfde_pkg::SCREEN_COLUMNS)) &&
                   (pr_reg < 11'(mfde_pkg::SCREEN_ROWS)) &&
                   (pt_addr_w < 16'(mfde_pkg::STORE_DEPTH));
    assign pt_addr_w = 16'(pr_reg[10:3]) * 16'(mfde_pkg::SCREEN_COLUMNS) + 16'(pc_reg);

    logic [7:0] mask;
    assign mask = 8'(1) << pr_reg[2:0];

    // Circle octant point from px (xa), py (ya)
    logic signed [10:0] cx, cy, oc, orw;
    assign cx = 11'(cmd_reg.x_first);
    assign cy = 11'(cmd_reg.y_first);
    always_comb begin
        unique case (oct_reg)
            3'd0: begin oc = cx + xa_reg; orw = cy + ya_reg; end
            3'd1: begin oc = cx + ya_reg; orw = cy + xa_reg; end
            3'd2: begin oc = cx - ya_reg; orw = cy + xa_reg; end
            3'd3: begin oc = cx - xa_reg; orw = cy + ya_reg; end
            3'd4: begin oc = cx - xa_reg; orw = cy - ya_reg; end
            3'd5: begin oc = cx - ya_reg; orw = cy - xa_reg; end
            3'd6: begin oc = cx + ya_reg; orw = cy - xa_reg; end
            default: begin oc = cx + xa_reg; orw = cy - ya_reg; end
        endcase
    end

    // Rectangle edge test
    logic rect_skip;
    assign rect_skip = !cmd_reg.color && (rc_reg != 9'd0) &&
                       (rc_reg != 9'(cmd_reg.rect_width) - 9'd1) &&
                       (rr_reg != 9'd0) &&
                       (rr_reg != 9'(cmd_reg.rect_height) - 9'd1);

    logic signed [11:0] e2;
    assign e2 = {err_reg, 1'b0};

    // Line reaches its end point
    logic line_end;
    assign line_end = (xa_reg == 11'(cmd_reg.x_second)) &&
                      (ya_reg == 11'(cmd_reg.y_second));

    // Start values of the point generators, taken from the queue head
    logic signed [10:0] st_adx, st_ady, st_xa, st_ya, st_err;
    logic               st_on;
    mfde_pkg::gen_t     st_gen;
    always_comb begin
        st_adx = (q_cmd.x_second > q_cmd.x_first) ?
            11'(q_cmd.x_second - q_cmd.x_first) : 11'(q_cmd.x_first - q_cmd.x_second);
        st_ady = (q_cmd.y_second > q_cmd.y_first) ?
            11'(q_cmd.y_second - q_cmd.y_first) : 11'(q_cmd.y_first - q_cmd.y_second);
        st_xa  = 11'(q_cmd.x_first);
        st_ya  = 11'(q_cmd.y_first);
        st_err = st_adx - st_ady;
        st_on  = q_cmd.color;
        unique case (q_cmd.action)
            mfde_pkg::ACT_LINE: st_gen = mfde_pkg::GEN_LINE;
            mfde_pkg::ACT_CIRCLE: begin
                st_gen = mfde_pkg::GEN_CIRCLE;
                st_xa  = 11'(q_cmd.radius);
                st_ya  = '0;
                st_err = 11'sd1 - 11'(q_cmd.radius);
            end
            mfde_pkg::ACT_RECT: begin
                // rectangle pixels always turn on
                st_gen = mfde_pkg::GEN_RECT;
                st_on  = 1'b1;
            end
            default: st_gen = mfde_pkg::GEN_PIXEL;
        endcase
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            mfde_pkg::ST_IDLE: begin
                if (init_reg) state_next = mfde_pkg::ST_CLEAR;
                else if (q_valid) begin
                    unique case (q_cmd.action)
                        mfde_pkg::ACT_CLEAR: state_next = mfde_pkg::ST_CLEAR;
                        mfde_pkg::ACT_PIXEL, mfde_pkg::ACT_LINE, mfde_pkg::ACT_CIRCLE:
                            state_next = mfde_pkg::ST_PT_GEN;
                        mfde_pkg::ACT_RECT:
                            state_next = (q_cmd.rect_width == 8'd0 ||
                                q_cmd.rect_height == 8'd0) ? mfde_pkg::ST_DONE
                                                           : mfde_pkg::ST_PT_GEN;
                        mfde_pkg::ACT_READ: state_next = mfde_pkg::ST_RD_READ;
                        default: state_next = mfde_pkg::ST_DONE;
                    endcase
                end
            end
            mfde_pkg::ST_CLEAR:
                if (clr_reg == 11'(mfde_pkg::STORE_DEPTH - 1))
                    state_next = init_reg ? mfde_pkg::ST_IDLE : mfde_pkg::ST_DONE;
            mfde_pkg::ST_PT_GEN:
                state_next = mfde_pkg::ST_PT_READ;
            mfde_pkg::ST_PT_READ: state_next = mfde_pkg::ST_PT_WAIT;
            mfde_pkg::ST_PT_WAIT: state_next = mfde_pkg::ST_PT_WRITE;
            mfde_pkg::ST_PT_WRITE:
                state_next = last_reg ? mfde_pkg::ST_DONE : mfde_pkg::ST_PT_GEN;
            mfde_pkg::ST_RD_READ: state_next = mfde_pkg::ST_RD_WAIT;
            mfde_pkg::ST_RD_WAIT: state_next = mfde_pkg::ST_DONE;
            mfde_pkg::ST_DONE:
                if (m_ready) state_next = mfde_pkg::ST_IDLE;
            default: state_next = mfde_pkg::ST_IDLE;
        endcase
    end

    // Outputs and memory port
    always_comb begin
        q_ready = 1'b0;
        we      = 1'b0;
        addr    = pt_addr_w[mfde_pkg::ADDR_W-1:0];
        wdata   = on_reg ? (data_reg | mask) : (data_reg & ~mask);
        m_valid = 1'b0;
        unique case (state_reg)
            mfde_pkg::ST_IDLE:  q_ready = !init_reg;
            mfde_pkg::ST_CLEAR: begin
                we    = 1'b1;
                addr  = clr_reg;
                wdata = 8'd0;
            end
            // skip the write for interior points of an outline rectangle
            mfde_pkg::ST_PT_WRITE: we = pt_in && (gen_reg != mfde_pkg::GEN_RECT || on_reg);
            mfde_pkg::ST_RD_READ:  addr = cmd_reg.read_index;
            mfde_pkg::ST_DONE:     m_valid = 1'b1;
            default: ;
        endcase
    end

    assign m_done_action = cmd_reg.action;
    assign m_read_data   = (cmd_reg.action == mfde_pkg::ACT_READ) ? data_reg : 8'd0;

    // Sequencer registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= mfde_pkg::ST_IDLE;
            init_reg  <= 1'b1;
            clr_reg   <= '0;
        end else begin
            state_reg <= state_next;
            if (state_reg == mfde_pkg::ST_CLEAR) begin
                // the sweep address wraps back to zero after the last entry
                clr_reg <= clr_reg + 11'd1;
                if (clr_reg == 11'(mfde_pkg::STORE_DEPTH - 1)) begin
                    init_reg <= 1'b0;
                end
            end
        end
    end

    // Generators: capture the command, emit one point per pass
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            mfde_pkg::ST_IDLE: if (q_valid && q_ready) begin
                cmd_reg <= q_cmd;
                on_reg  <= st_on;
                gen_reg <= st_gen;
                oct_reg <= 3'd0;
                rc_reg  <= '0;
                rr_reg  <= '0;
                xa_reg  <= st_xa;
                ya_reg  <= st_ya;
                dx_reg  <= st_adx;
                dy_reg  <= -st_ady;
                sx_reg  <= (q_cmd.x_first < q_cmd.x_second) ? 2'sd1 : -2'sd1;
                sy_reg  <= (q_cmd.y_first < q_cmd.y_second) ? 2'sd1 : -2'sd1;
                err_reg <= st_err;
            end
            mfde_pkg::ST_PT_GEN: begin
                unique case (gen_reg)
                    mfde_pkg::GEN_PIXEL: begin
                        pc_reg <= xa_reg; pr_reg <= ya_reg; last_reg <= 1'b1;
                    end
                    mfde_pkg::GEN_LINE: begin
                        pc_reg <= xa_reg; pr_reg <= ya_reg;
                        if (line_end) begin
                            last_reg <= 1'b1;
                        end else begin
                            last_reg <= 1'b0;
                            err_reg <= err_reg + ((e2 >= 12'(dy_reg)) ? dy_reg : 11'sd0)
                                               + ((e2 <= 12'(dx_reg)) ? dx_reg : 11'sd0);
                            if (e2 >= 12'(dy_reg)) xa_reg <= xa_reg + 11'(sx_reg);
                            if (e2 <= 12'(dx_reg)) ya_reg <= ya_reg + 11'(sy_reg);
                        end
                    end
                    mfde_pkg::GEN_CIRCLE: begin
                        pc_reg  <= oc; pr_reg <= orw;
                        oct_reg <= oct_reg + 3'd1;
                        if (oct_reg == 3'd7) begin
                            // step the midpoint loop after the eighth point
                            if (err_reg < 11'sd0) begin
                                err_reg <= err_reg + 11'sd2 * (ya_reg + 11'sd1) + 11'sd1;
                                last_reg <= !(xa_reg >= ya_reg + 11'sd1);
                            end else begin
                                err_reg <= err_reg + 11'sd2 * (ya_reg - xa_reg + 11'sd2)
                                           + 11'sd1;
                                xa_reg  <= xa_reg - 11'sd1;
                                last_reg <= !(xa_reg - 11'sd1 >= ya_reg + 11'sd1);
                            end
                            ya_reg <= ya_reg + 11'sd1;
                        end else begin
                            last_reg <= 1'b0;
                        end
                    end
                    default: begin
                        pc_reg <= xa_reg + 11'(rc_reg);
                        pr_reg <= ya_reg + 11'(rr_reg);
                        on_reg <= !rect_skip;
                        if (rr_reg == 9'(cmd_reg.rect_height) - 9'd1) begin
                            rr_reg <= '0;
                            rc_reg <= rc_reg + 9'd1;
                            last_reg <= (rc_reg == 9'(cmd_reg.rect_width) - 9'd1);
                        end else begin
                            rr_reg <= rr_reg + 9'd1;
                            last_reg <= 1'b0;
                        end
                    end
                endcase
            end
            mfde_pkg::ST_PT_WAIT: data_reg <= rdata;
            mfde_pkg::ST_RD_WAIT: data_reg <= rdata;
            default: ;
        endcase
    end

    a_done_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == mfde_pkg::ST_DONE && !m_ready) |=> m_valid)
        else $error("result dropped while stalled");
    a_done_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> $stable(m_done_action))
        else $error("result changed while stalled");
    a_no_take_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != mfde_pkg::ST_IDLE) |-> !q_ready)
        else $error("command taken while busy");

endmodule

@@ src/mono_framebuffer_draw_engine.sv @@
// ----------------------------------------------------------------------------
// mono_framebuffer_draw_engine
// One-bit-per-pixel frame store with pixel, line, circle and rectangle drawing.
// ----------------------------------------------------------------------------
// Commands enter on the s_ channel; each produces one completion on m_.
// s_axis_tuser carries the action; s_axis_tdata the coordinates, sizes,
// color and read index. m_axis_tdata carries the read byte and
// m_axis_tuser the finished action code.
// A front queue of two commands accepts transfers while the back end draws.
// The back end picks a command from the queue when idle, then runs its
// body, then presents the completion; each plotted pixel passes through
// generate, read, wait and write states (read-modify-write in the single
// store port): a line plots max(dx,dy)+1 pixels, a circle eight per
// midpoint step, a rectangle w*h; a read passes a read and a wait state, a
// clear writes all 2048 entries, and an empty rectangle or unknown action
// has no body. The back end takes the next command only after the
// completion is taken. After reset all 2048 store entries are cleared before the first
// command is started; commands may still queue meanwhile.
// While the receiver stalls the completion is held and the back end waits;
// the queue keeps accepting until it holds two commands.
module mono_framebuffer_draw_engine (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // x_first[7:0], y_first[15:8], x_second[23:16], y_second[31:24],
    // radius[39:32], rect_width[47:40], rect_height[55:48], color[56],
    // read_index[67:57], zero fill to 72
    input  logic [71:0] s_axis_tdata,
    // action[2:0]
    input  logic [2:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // read_data[7:0]
    output logic [7:0]  m_axis_tdata,
    // done_action[2:0]
    output logic [2:0]  m_axis_tuser
);

    mfde_pkg::cmd_t in_cmd, q_cmd;
    logic           q_valid, q_ready;

    assign in_cmd.action      = mfde_pkg::action_t'(s_axis_tuser);
    assign in_cmd.x_first     = s_axis_tdata[7:0];
    assign in_cmd.y_first     = s_axis_tdata[15:8];
    assign in_cmd.x_second    = s_axis_tdata[23:16];
    assign in_cmd.y_second    = s_axis_tdata[31:24];
    assign in_cmd.radius      = s_axis_tdata[39:32];
    assign in_cmd.rect_width  = s_axis_tdata[47:40];
    assign in_cmd.rect_height = s_axis_tdata[55:48];
    assign in_cmd.color       = s_axis_tdata[56];
    assign in_cmd.read_index  = s_axis_tdata[67:57];

    mfde_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_cmd(in_cmd),
        .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd)
    );

    mfde_back u_back (
        .aclk(aclk), .aresetn(aresetn),
        .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd),
        .m_valid(m_axis_tvalid), .m_ready(m_axis_tready),
        .m_read_data(m_axis_tdata), .m_done_action(m_axis_tuser)
    );

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the monochrome frame-store draw engine.
// ----------------------------------------------------------------------------
// Drawing commands are streamed into the engine, and a local copy of the
// paged frame store is kept up to date with them. Every completion is
// checked against the next expected read byte and action code. Read-back
// commands expose the store contents, so drawing errors show up as wrong
// read bytes. The run covers directed edge cases, then random commands
// under several idle and stall patterns, including one long receiver
// hold-off that backs the engine up.
// ----------------------------------------------------------------------------
module testbench;

    localparam int  RANDOM_ITEMS = 1650;
    localparam int  HOLD_CYCLES  = 3000;
    localparam int  DRAIN_CYCLES = 400;
    localparam longint CYCLE_LIMIT = 12_000_000;

    typedef struct {
        logic [7:0]          read_data;
        mfde_pkg::action_t   done_action;
    } completion_t;

    // Scoreboard: local copy of the store and the completions still owed
    class draw_scoreboard;
        logic [7:0]  pixels [mfde_pkg::STORE_DEPTH];
        completion_t owed [$];
        int          errors;

        function new();
            foreach (pixels[i]) pixels[i] = 8'h00;
            errors = 0;
        endfunction

        task report(input string msg);
            $display("mismatch: %s", msg);
            errors++;
        endtask

        // Drop pixels outside the screen, otherwise update one bit
        function void plot(input int col, input int row, input bit on);
            int addr;
            if (col < 0 || row < 0 || col >= mfde_pkg::SCREEN_COLUMNS ||
                row >= mfde_pkg::SCREEN_ROWS)
                return;
            addr = (row / 8) * mfde_pkg::SCREEN_COLUMNS + col;
            if (addr >= mfde_pkg::STORE_DEPTH)
                return;
            pixels[addr][row % 8] = on;
        endfunction

        function void plot_segment(input int xa, input int ya, input int xb,
                                   input int yb, input bit on);
            int dx, dy, sx, sy, err, e2;
            dx = (xb > xa) ? xb - xa : xa - xb;
            dy = -((yb > ya) ? yb - ya : ya - yb);
            sx = (xa < xb) ? 1 : -1;
            sy = (ya < yb) ? 1 : -1;
            err = dx + dy;
            forever begin
                plot(xa, ya, on);
                if (xa == xb && ya == yb)
                    break;
                e2 = 2 * err;
                if (e2 >= dy) begin
                    err += dy;
                    xa += sx;
                end
                if (e2 <= dx) begin
                    err += dx;
                    ya += sy;
                end
            end
        endfunction

        function void plot_ring(input int cx, input int cy, input int r,
                                input bit on);
            int px, py, err;
            px = r;
            py = 0;
            err = 1 - r;
            while (px >= py) begin
                plot(cx + px, cy + py, on);
                plot(cx + py, cy + px, on);
                plot(cx - py, cy + px, on);
                plot(cx - px, cy + py, on);
                plot(cx - px, cy - py, on);
                plot(cx - py, cy - px, on);
                plot(cx + py, cy - px, on);
                plot(cx + px, cy - py, on);
                py++;
                if (err < 0) begin
                    err += 2 * py + 1;
                end else begin
                    px--;
                    err += 2 * (py - px) + 1;
                end
            end
        endfunction

        // Rectangle pixels always turn on; outline skips the interior
        function void plot_box(input int left, input int top, input int w,
                               input int h, input bit filled);
            if (w <= 0 || h <= 0)
                return;
            for (int c = left; c < left + w; c++) begin
                for (int r = top; r < top + h; r++) begin
                    if (!filled && c > left && c < left + w - 1 &&
                        r > top && r < top + h - 1)
                        continue;
                    plot(c, r, 1'b1);
                end
            end
        endfunction

        // Apply one accepted command and queue its completion
        function void note_command(input logic [71:0] d, input logic [2:0] u);
            completion_t c;
            mfde_pkg::action_t act;
            act = mfde_pkg::action_t'(u);
            c.read_data = 8'h00;
            c.done_action = act;
            unique case (act)
                mfde_pkg::ACT_CLEAR:  foreach (pixels[i]) pixels[i] = 8'h00;
                mfde_pkg::ACT_PIXEL:  plot(int'(d[7:0]), int'(d[15:8]), d[56]);
                mfde_pkg::ACT_LINE:   plot_segment(int'(d[7:0]), int'(d[15:8]),
                                                   int'(d[23:16]), int'(d[31:24]), d[56]);
                mfde_pkg::ACT_CIRCLE: plot_ring(int'(d[7:0]), int'(d[15:8]),
                                                int'(d[39:32]), d[56]);
                mfde_pkg::ACT_RECT:   plot_box(int'(d[7:0]), int'(d[15:8]),
                                               int'(d[47:40]), int'(d[55:48]), d[56]);
                mfde_pkg::ACT_READ:   c.read_data = pixels[d[67:57]];
                default:    ;
            endcase
            owed.push_back(c);
        endfunction

        task check_completion(input logic [7:0] d, input logic [2:0] u);
            completion_t c;
            if (owed.size() == 0) begin
                report($sformatf("unexpected completion %h/%h", d, u));
                return;
            end
            c = owed.pop_front();
            if (u !== c.done_action)
                report($sformatf("done_action %0d, want %0d", u, c.done_action));
            if (d !== c.read_data)
                report($sformatf("read_data %h, want %h (action %0d)",
                                 d, c.read_data, c.done_action));
        endtask
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    // x_first, y_first, x_second, y_second, radius, rect_width,
    // rect_height, color, read_index, zero fill (lowest bit up)
    logic [71:0] s_axis_tdata = '0;
    // action
    logic [2:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // read_data
    logic [7:0]  m_axis_tdata;
    // done_action
    logic [2:0]  m_axis_tuser;

    draw_scoreboard board = new();
    int     phase = 0;      // 0 none, 1 sender idle, 2 receiver stall, 3 both, 4 hold-off
    bit     held = 1'b0;
    int     hold_left = 0;
    longint cycles = 0;

    mono_framebuffer_draw_engine dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #5 aclk = ~aclk;

    // Watchdog
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Count down the one long receiver hold-off
    always @(posedge aclk) begin
        if (phase == 4 && !held) begin
            held      <= 1'b1;
            hold_left <= HOLD_CYCLES;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Receiver: check completions, then pick next ready
    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready)
            board.check_completion(m_axis_tdata, m_axis_tuser);
        if (hold_left > 0) begin
            m_axis_tready <= 1'b0;
        end else if (phase == 2) begin
            m_axis_tready <= ($urandom_range(0, 99) >= 68);
        end else if (phase == 3) begin
            m_axis_tready <= ($urandom_range(0, 99) >= 12);
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    function automatic logic [71:0] pack_command(
        input logic [7:0] x1, input logic [7:0] y1,
        input logic [7:0] x2, input logic [7:0] y2, input logic [7:0] rad,
        input logic [7:0] w, input logic [7:0] h, input logic color,
        input logic [10:0] idx);
        return {4'b0, idx, color, h, w, rad, y2, x2, y1, x1};
    endfunction

    // Offer one command, with idle cycles first as the phase asks
    task drive_command(input mfde_pkg::action_t act, input logic [71:0] d);
        int idle_pct;
        idle_pct = (phase == 1) ? 68 : (phase == 3) ? 12 : 0;
        while ($urandom_range(0, 99) < idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= d;
        s_axis_tuser  <= act;
        do @(posedge aclk); while (!s_axis_tready);
        board.note_command(d, act);
    endtask

    // Random action, weighted toward cheap shapes and frequent read-back
    function automatic mfde_pkg::action_t random_action();
        int sel;
        sel = $urandom_range(0, 99);
        return (sel < 35) ? mfde_pkg::ACT_READ : (sel < 55) ? mfde_pkg::ACT_PIXEL :
               (sel < 70) ? mfde_pkg::ACT_LINE : (sel < 83) ? mfde_pkg::ACT_CIRCLE :
               (sel < 96) ? mfde_pkg::ACT_RECT : (sel < 97) ? mfde_pkg::ACT_CLEAR :
               (sel < 98) ? mfde_pkg::ACT_BAD6 : mfde_pkg::ACT_BAD7;
    endfunction

    // Random operands for any action
    function automatic logic [71:0] random_operands();
        logic [7:0] x1, y1, x2, y2, rad, w, h;
        x1 = ($urandom_range(0, 9) < 8) ? 8'($urandom_range(0, 140))
                                        : 8'($urandom_range(0, 255));
        y1 = ($urandom_range(0, 9) < 8) ? 8'($urandom_range(0, 140))
                                        : 8'($urandom_range(0, 255));
        x2 = 8'($urandom_range(0, 255));
        y2 = 8'($urandom_range(0, 255));
        rad = ($urandom_range(0, 19) == 0) ? 8'($urandom_range(0, 255))
                                           : 8'($urandom_range(0, 40));
        w = 8'($urandom_range(0, 20));
        h = 8'($urandom_range(0, 20));
        // Occasionally one long, thin side
        if ($urandom_range(0, 19) == 0) begin
            w = 8'($urandom_range(0, 255));
            h = 8'($urandom_range(0, 3));
        end else if ($urandom_range(0, 19) == 0) begin
            w = 8'($urandom_range(0, 3));
            h = 8'($urandom_range(0, 255));
        end
        return pack_command(x1, y1, x2, y2, rad, w, h, 1'($urandom_range(0, 1)),
                            11'($urandom_range(0, 2047)));
    endfunction

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed edge cases
        drive_command(mfde_pkg::ACT_PIXEL, pack_command(0, 0, 0, 0, 0, 0, 0, 1, 0));
        drive_command(mfde_pkg::ACT_PIXEL, pack_command(127, 127, 0, 0, 0, 0, 0, 1, 0));
        drive_command(mfde_pkg::ACT_PIXEL, pack_command(128, 5, 0, 0, 0, 0, 0, 1, 0));
        drive_command(mfde_pkg::ACT_PIXEL, pack_command(255, 255, 0, 0, 0, 0, 0, 1, 0));
        drive_command(mfde_pkg::ACT_READ, pack_command(0, 0, 0, 0, 0, 0, 0, 0, 0));
        drive_command(mfde_pkg::ACT_READ, pack_command(0, 0, 0, 0, 0, 0, 0, 0, 2047));
        drive_command(mfde_pkg::ACT_PIXEL, pack_command(0, 0, 0, 0, 0, 0, 0, 0, 0));
        drive_command(mfde_pkg::ACT_READ,
                      pack_command(255, 255, 255, 255, 255, 255, 255, 1, 0));
        drive_command(mfde_pkg::ACT_LINE, pack_command(0, 0, 255, 255, 0, 0, 0, 1, 0));
        drive_command(mfde_pkg::ACT_LINE, pack_command(255, 0, 0, 200, 0, 0, 0, 1, 0));
        drive_command(mfde_pkg::ACT_LINE, pack_command(10, 64, 10, 64, 0, 0, 0, 0, 0));
        drive_command(mfde_pkg::ACT_CIRCLE, pack_command(64, 64, 0, 0, 0, 0, 0, 1, 0));
        drive_command(mfde_pkg::ACT_CIRCLE, pack_command(64, 64, 0, 0, 255, 0, 0, 1, 0));
        drive_command(mfde_pkg::ACT_CIRCLE, pack_command(0, 127, 0, 0, 30, 0, 0, 1, 0));
        drive_command(mfde_pkg::ACT_RECT, pack_command(0, 0, 0, 0, 0, 255, 3, 1, 0));
        drive_command(mfde_pkg::ACT_RECT, pack_command(120, 120, 0, 0, 0, 3, 255, 0, 0));
        drive_command(mfde_pkg::ACT_RECT, pack_command(40, 40, 0, 0, 0, 12, 9, 0, 0));
        drive_command(mfde_pkg::ACT_RECT, pack_command(40, 40, 0, 0, 0, 0, 9, 1, 0));
        drive_command(mfde_pkg::ACT_RECT, pack_command(40, 40, 0, 0, 0, 9, 0, 1, 0));
        drive_command(mfde_pkg::ACT_READ, pack_command(0, 0, 0, 0, 0, 0, 0, 0, 133));
        drive_command(mfde_pkg::ACT_BAD6,
                      pack_command(255, 255, 255, 255, 255, 255, 255, 1, 2047));
        drive_command(mfde_pkg::ACT_BAD7, pack_command(3, 3, 3, 3, 3, 3, 3, 0, 5));
        drive_command(mfde_pkg::ACT_CLEAR, pack_command(0, 0, 0, 0, 0, 0, 0, 0, 0));
        drive_command(mfde_pkg::ACT_READ, pack_command(0, 0, 0, 0, 0, 0, 0, 0, 16));

        // Random traffic through each idle pattern
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            phase = (i * 5) / RANDOM_ITEMS;
            drive_command(random_action(), random_operands());
        end
        s_axis_tvalid <= 1'b0;
        phase = 0;

        // Drain, then watch for stray completions
        while (board.owed.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (board.errors == 0 && board.owed.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule

@@ files.f @@
src/mfde_pkg.sv
src/mfde_ram.sv
src/mfde_front.sv
src/mfde_back.sv
src/mono_framebuffer_draw_engine.sv
bench/testbench.sv
